[rtl/core/arbb_pkg.sv]
// Package for the affine rectangle bounding box block.
// Holds fixed-point widths, register index codes and saturation limits.
// No dependencies.
package arbb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int TERM_W    = PROD_W + 1 - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;
  localparam int TDATA_W   = 4 * COORD_W;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LANES = 4;

  localparam logic signed [COORD_W-1:0] MAT_ONE  = COORD_W'(1 << FRAC_BITS);
  localparam logic signed [COORD_W-1:0] MAT_ZERO = '0;
  localparam logic [COORD_W-1:0] S32_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] S32_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] U32_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAT_A  = 3'd0,
    REG_MAT_B  = 3'd1,
    REG_MAT_TX = 3'd2,
    REG_MAT_C  = 3'd3,
    REG_MAT_D  = 3'd4,
    REG_MAT_TY = 3'd5
  } cfg_reg_e;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

[rtl/core/affine_rect_bounding_box.sv]
// Affine rectangle bounding box, top level.
// Maps the four corners of a rectangle through a 2D affine matrix and
// returns the axis-aligned bounding box. Depends on arbb_pkg.
//
// Channels: s_axis carries one rectangle per transaction, m_axis one box
// per transaction. The cfg channel writes the six matrix registers
// (index 0..5: a, b, tx, c, d, ty); other indexes are ignored. Write the
// matrix only while no transaction is in flight.
// Pipeline: five register stages (products, term sums, min/max per
// coefficient, corner sums, saturation). Throughput: one rectangle per
// cycle while the output is not stalled (see Stall).
// Reset: clears all stage valids and loads the identity matrix.
// Stall: when m_axis_tready_i is low, the output holds and each stage holds
// only if the stage behind it is full; empty stages keep filling, so input
// transactions are still taken until the pipeline is full.
module affine_rect_bounding_box
  import arbb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // rect_left, rect_top, rect_width, rect_height
  input  logic [TDATA_W-1:0]   s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // box_left, box_top, box_width, box_height
  output logic [TDATA_W-1:0]   m_axis_tdata_o
);

  logic signed [COORD_W-1:0] mat_a_q, mat_b_q, mat_tx_q, mat_c_q, mat_d_q, mat_ty_q;

  logic signed [COORD_W-1:0] in_left, in_top, in_width, in_height;
  logic signed [COORD_W-1:0] coef   [NUM_LANES];
  logic signed [COORD_W-1:0] base   [NUM_LANES];
  logic signed [COORD_W-1:0] extent [NUM_LANES];

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  prod_t pb_d [NUM_LANES];
  prod_t pb_q [NUM_LANES];
  prod_t pe_d [NUM_LANES];
  prod_t pe_q [NUM_LANES];
  term_t t0_d [NUM_LANES];
  term_t t0_q [NUM_LANES];
  term_t t1_d [NUM_LANES];
  term_t t1_q [NUM_LANES];
  term_t lo_d [NUM_LANES];
  term_t lo_q [NUM_LANES];
  term_t hi_d [NUM_LANES];
  term_t hi_q [NUM_LANES];
  sum_t  mn_d [2];
  sum_t  mn_q [2];
  sum_t  dl_d [2];
  sum_t  dl_q [2];
  logic [COORD_W-1:0] pos_d [2];
  logic [COORD_W-1:0] pos_q [2];
  logic [COORD_W-1:0] ext_d [2];
  logic [COORD_W-1:0] ext_q [2];

  logic signed [PROD_W:0]    psum [NUM_LANES];
  logic signed [COORD_W-1:0] trans [2];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_a_q  <= MAT_ONE;
      mat_b_q  <= MAT_ZERO;
      mat_tx_q <= MAT_ZERO;
      mat_c_q  <= MAT_ZERO;
      mat_d_q  <= MAT_ONE;
      mat_ty_q <= MAT_ZERO;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAT_A:  mat_a_q  <= cfg_data_i;
        REG_MAT_B:  mat_b_q  <= cfg_data_i;
        REG_MAT_TX: mat_tx_q <= cfg_data_i;
        REG_MAT_C:  mat_c_q  <= cfg_data_i;
        REG_MAT_D:  mat_d_q  <= cfg_data_i;
        REG_MAT_TY: mat_ty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_left   = s_axis_tdata_i[COORD_W-1:0];
  assign in_top    = s_axis_tdata_i[2*COORD_W-1:COORD_W];
  assign in_width  = s_axis_tdata_i[3*COORD_W-1:2*COORD_W];
  assign in_height = s_axis_tdata_i[4*COORD_W-1:3*COORD_W];

  assign coef[0]   = mat_a_q;
  assign coef[1]   = mat_b_q;
  assign coef[2]   = mat_c_q;
  assign coef[3]   = mat_d_q;
  assign base[0]   = in_left;
  assign base[1]   = in_top;
  assign base[2]   = in_left;
  assign base[3]   = in_top;
  assign extent[0] = in_width;
  assign extent[1] = in_height;
  assign extent[2] = in_width;
  assign extent[3] = in_height;
  assign trans[0]  = mat_tx_q;
  assign trans[1]  = mat_ty_q;

  assign en5 = !v5_q || m_axis_tready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      pb_d[l] = PROD_W'(coef[l]) * PROD_W'(base[l]);
      pe_d[l] = PROD_W'(coef[l]) * PROD_W'(extent[l]);
      psum[l] = (PROD_W+1)'(pb_q[l]) + (PROD_W+1)'(pe_q[l]);
      t0_d[l] = TERM_W'(pb_q[l] >>> FRAC_BITS);
      t1_d[l] = psum[l][PROD_W:FRAC_BITS];
      if (t1_q[l] < t0_q[l]) begin
        lo_d[l] = t1_q[l];
        hi_d[l] = t0_q[l];
      end else begin
        lo_d[l] = t0_q[l];
        hi_d[l] = t1_q[l];
      end
    end
    for (int k = 0; k < 2; k++) begin
      mn_d[k] = SUM_W'(lo_q[2*k]) + SUM_W'(lo_q[2*k+1]) + SUM_W'(trans[k]);
      dl_d[k] = (SUM_W'(hi_q[2*k]) - SUM_W'(lo_q[2*k]))
              + (SUM_W'(hi_q[2*k+1]) - SUM_W'(lo_q[2*k+1]));
      if ((&mn_q[k][SUM_W-1:COORD_W-1]) || !(|mn_q[k][SUM_W-1:COORD_W-1])) begin
        pos_d[k] = mn_q[k][COORD_W-1:0];
      end else if (mn_q[k][SUM_W-1]) begin
        pos_d[k] = S32_MIN;
      end else begin
        pos_d[k] = S32_MAX;
      end
      if (|dl_q[k][SUM_W-1:COORD_W]) begin
        ext_d[k] = U32_MAX;
      end else begin
        ext_d[k] = dl_q[k][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pb_q <= pb_d;
      pe_q <= pe_d;
    end
    if (en2) begin
      t0_q <= t0_d;
      t1_q <= t1_d;
    end
    if (en3) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en4) begin
      mn_q <= mn_d;
      dl_q <= dl_d;
    end
    if (en5) begin
      pos_q <= pos_d;
      ext_q <= ext_d;
    end
  end

  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = {ext_q[1], ext_q[0], pos_q[1], pos_q[0]};

endmodule
